// ===== rtl/palt_pkg.sv =====
// ----------------------------------------------------------------------------
// palt_pkg
// Shared types and constants for the peer address learning table.
// ----------------------------------------------------------------------------
`default_nettype none

package palt_pkg;

  localparam int POOL_ENTRIES = 8;
  localparam int IDX_W        = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int RESULT_CAP   = 8;
  localparam int CNT_W        = $clog2(RESULT_CAP + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_PORT = 2'd1;

  localparam logic [7:0]  OWN_ID_RST     = 8'd1;
  localparam logic [15:0] BCAST_PORT_RST = 16'd8888;

  localparam logic [7:0]  HDR_MARK   = 8'hFE;
  localparam logic [7:0]  HDR_TYPE_A = 8'h7C;
  localparam logic [7:0]  HDR_TYPE_B = 8'h7F;
  localparam logic [31:0] ALL_ONES_ADDR = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_LEARN     = 2'd0;
  localparam logic [1:0] KIND_UNICAST   = 2'd1;
  localparam logic [1:0] KIND_BROADCAST = 2'd2;

  localparam logic [1:0] STAT_IGNORED = 2'd0;
  localparam logic [1:0] STAT_REFRESH = 2'd1;
  localparam logic [1:0] STAT_ADDED   = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  localparam logic [1:0] FAIL_FREE = 2'd2;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] addr;
    logic [15:0] port;
    logic [1:0]  fail_count;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic             full;   // 0: fail count only
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  learn_status;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/palt_if.sv =====
// ----------------------------------------------------------------------------
// palt_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface palt_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  frame_byte0;
  logic [7:0]  frame_byte1;
  logic [7:0]  frame_byte2;
  logic [7:0]  frame_byte3;
  logic [31:0] source_addr;
  logic [15:0] source_port;

  modport source (
    output valid, mode, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
           source_addr, source_port,
    input  ready
  );
  modport sink (
    input  valid, mode, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
           source_addr, source_port,
    output ready
  );
endinterface

interface palt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  learn_status;
  logic [31:0] dest_addr;
  logic [15:0] dest_port;
  logic        last;

  modport source (
    output valid, kind, learn_status, dest_addr, dest_port, last,
    input  ready
  );
  modport sink (
    input  valid, kind, learn_status, dest_addr, dest_port, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/palt_table.sv =====
// ----------------------------------------------------------------------------
// palt_table
// Peer entry storage: one read port at the scan index, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module palt_table
  import palt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] rd_idx,
  input  wire tbl_wr_t          wr,
  output entry_t                rd
);

  entry_t entries [POOL_ENTRIES];

  assign rd = entries[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        entries[i] <= '{id: 8'd0, addr: 32'd0, port: 16'd0, fail_count: FAIL_FREE};
      end
    end else if (wr.en) begin
      if (wr.full) begin
        entries[wr.idx] <= wr.data;
      end else begin
        entries[wr.idx].fail_count <= wr.data.fail_count;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/palt_seq.sv =====
// ----------------------------------------------------------------------------
// palt_seq
// Scan sequencer: with a single id comparator, walks the table one entry a
// cycle unless stalled; updates counts/entries and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module palt_seq
  import palt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  own_id,
  input  wire logic [15:0] broadcast_port,
  palt_in_if.sink          in_ch,
  palt_out_if.source       out_ch,
  output logic [IDX_W-1:0] rd_idx,
  input  wire entry_t      tbl_rd,
  output tbl_wr_t          tbl_wr
);

  state_t state, state_next;

  logic [IDX_W-1:0] idx;
  logic             mode_r;
  logic             ok_r;
  logic [7:0]       key_r;
  logic [31:0]      addr_r;
  logic [15:0]      port_r;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             matched;
  logic             pend_valid;
  logic [31:0]      pend_addr;
  logic [15:0]      pend_port;
  logic [CNT_W-1:0] nres;

  logic out_valid;
  res_t out_item;

  logic hdr_ok, accept, id_hit, live, send_match, cand, can_push, stall;
  logic idx_last, fin_push, fin_go, push;
  res_t push_item;

  assign hdr_ok = (in_ch.frame_byte0 == HDR_MARK) &&
                  ((in_ch.frame_byte1 == HDR_TYPE_A) || (in_ch.frame_byte1 == HDR_TYPE_B));
  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign rd_idx     = idx;
  assign id_hit     = (tbl_rd.id == key_r);
  assign live       = (tbl_rd.fail_count < FAIL_FREE);
  assign send_match = mode_r && id_hit && live;
  assign cand       = send_match && (tbl_rd.addr[7:0] != 8'd0) &&
                      (nres < CNT_W'(RESULT_CAP));
  assign can_push   = !out_valid || out_ch.ready;
  assign stall      = (state == S_SCAN) && cand && pend_valid && !can_push;
  assign idx_last   = (idx == IDX_W'(POOL_ENTRIES - 1));
  assign fin_push   = !mode_r || pend_valid || !matched;
  assign fin_go     = !fin_push || can_push;

  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_item  = '0;
    tbl_wr     = '0;
    case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.mode) begin
            state_next = hdr_ok ? S_SCAN : S_FINISH;
          end else begin
            state_next = (hdr_ok && in_ch.frame_byte2 == own_id) ? S_SCAN : S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (mode_r) begin
          if (!stall) begin
            if (send_match) begin
              tbl_wr.en              = 1'b1;
              tbl_wr.idx             = idx;
              tbl_wr.data            = tbl_rd;
              tbl_wr.data.fail_count = tbl_rd.fail_count + 2'd1;
            end
            if (cand && pend_valid) begin
              push      = 1'b1;
              push_item = '{kind: KIND_UNICAST, learn_status: STAT_IGNORED,
                            dest_addr: pend_addr, dest_port: pend_port, last: 1'b0};
            end
            if (idx_last) begin
              state_next = S_FINISH;
            end
          end
        end else if (id_hit || idx_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_go) begin
          state_next = S_IDLE;
          push       = fin_push;
          if (!mode_r) begin
            push_item.kind = KIND_LEARN;
            push_item.last = 1'b1;
            if (!ok_r) begin
              push_item.learn_status = STAT_IGNORED;
            end else if (hit) begin
              push_item.learn_status = STAT_REFRESH;
            end else if (free_found) begin
              push_item.learn_status = STAT_ADDED;
            end else begin
              push_item.learn_status = STAT_FULL;
            end
            if (ok_r && (hit || free_found)) begin
              tbl_wr.en   = 1'b1;
              tbl_wr.full = 1'b1;
              tbl_wr.idx  = hit ? hit_idx : free_idx;
              tbl_wr.data = '{id: key_r, addr: addr_r, port: port_r, fail_count: 2'd0};
            end
          end else if (pend_valid) begin
            push_item = '{kind: KIND_UNICAST, learn_status: STAT_IGNORED,
                          dest_addr: pend_addr, dest_port: pend_port, last: 1'b1};
          end else begin
            push_item = '{kind: KIND_BROADCAST, learn_status: STAT_IGNORED,
                          dest_addr: ALL_ONES_ADDR, dest_port: broadcast_port, last: 1'b1};
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
      matched    <= 1'b0;
      pend_valid <= 1'b0;
      nres       <= '0;
      idx        <= '0;
    end else if (accept) begin
      idx        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      matched    <= 1'b0;
      pend_valid <= 1'b0;
      nres       <= '0;
    end else if (state == S_SCAN && !stall) begin
      idx <= IDX_W'(idx + 1'b1);
      if (!mode_r) begin
        if (id_hit) begin
          hit     <= 1'b1;
          hit_idx <= idx;
        end
        if (!free_found && !live) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
      end else begin
        if (send_match) begin
          matched <= 1'b1;
        end
        if (cand) begin
          pend_valid <= 1'b1;
          pend_addr  <= tbl_rd.addr;
          pend_port  <= tbl_rd.port;
          nres       <= nres + 1'b1;
        end
      end
    end else if (state == S_FINISH && fin_go) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_ch.mode;
      key_r  <= in_ch.mode ? in_ch.frame_byte2 : in_ch.frame_byte3;
      ok_r   <= hdr_ok && (in_ch.mode || in_ch.frame_byte2 == own_id);
      addr_r <= in_ch.source_addr;
      port_r <= in_ch.source_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_item <= push_item;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = out_item.kind;
  assign out_ch.learn_status = out_item.learn_status;
  assign out_ch.dest_addr    = out_item.dest_addr;
  assign out_ch.dest_port    = out_item.dest_port;
  assign out_ch.last         = out_item.last;

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("unicast item left pending on return to idle");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || out_ch.ready))
    else $error("result pushed over an untaken item");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    nres <= CNT_W'(RESULT_CAP))
    else $error("result count beyond cap");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (tbl_wr.en && !tbl_wr.full) |-> (mode_r && $past(state) != S_IDLE || state == S_SCAN))
    else $error("count update outside a send scan");

endmodule

`default_nettype wire

// ===== rtl/peer_address_learning_table.sv =====
// ----------------------------------------------------------------------------
// peer_address_learning_table
// Peer id to address/port table with learn and send lookup items.
// ----------------------------------------------------------------------------
// One item at a time. After an item is accepted, a single id comparator
// walks the table one entry per cycle while the scan is not paused, and
// the finishing state then completes the item. A learn item stops its
// scan at the first id match; an item with a bad header, or a learn item
// for another node, skips the scan. Unicast results leave as the scan
// proceeds; the scan pauses only when a further unicast result is found
// while the result register still holds an item not yet taken, and the
// finishing cycle likewise waits for room. Configuration is taken from
// the write port at any time; registers reset to own id 1 and port 8888.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_address_learning_table
  import palt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  palt_in_if.sink                    in_ch,
  palt_out_if.source                 out_ch
);

  logic [7:0]  own_id;
  logic [15:0] broadcast_port;

  logic [IDX_W-1:0] rd_idx;
  entry_t           tbl_rd;
  tbl_wr_t          tbl_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id         <= OWN_ID_RST;
      broadcast_port <= BCAST_PORT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OWN_ID:     own_id         <= cfg_data[7:0];
        REG_BCAST_PORT: broadcast_port <= cfg_data;
        default: ;
      endcase
    end
  end

  palt_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .wr     (tbl_wr),
    .rd     (tbl_rd)
  );

  palt_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .own_id         (own_id),
    .broadcast_port (broadcast_port),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .rd_idx         (rd_idx),
    .tbl_rd         (tbl_rd),
    .tbl_wr         (tbl_wr)
  );

endmodule

`default_nettype wire
